// File: rtl/ets_pkg.sv
package ets_pkg;

  // engine phase codes
  typedef enum logic [2:0] {
    PH_RUNNING    = 3'd0,
    PH_BOOST1     = 3'd1,
    PH_BOOST2     = 3'd2,
    PH_BOOST3     = 3'd3,
    PH_BOOST4     = 3'd4,
    PH_BRAKE_HOLD = 3'd5,
    PH_BRAKE_LOW  = 3'd6
  } phase_t;

  // opcodes
  localparam logic [1:0] OP_UPDATE = 2'd0;
  localparam logic [1:0] OP_BOOST  = 2'd1;
  localparam logic [1:0] OP_BRAKE  = 2'd2;

  // register byte addresses
  localparam logic [2:0] ADDR_LOW_THROTTLE  = 3'd0;
  localparam logic [2:0] ADDR_LINK_ATTACHED = 3'd4;

  localparam logic [10:0] THR_LOWEST  = 11'd980;
  localparam logic [10:0] THR_HIGHEST = 11'd2000;
  localparam logic [10:0] THR_RESET   = 11'd1150;
  localparam logic [15:0] LOW_RESET   = 16'd1150;
  localparam logic [15:0] LOW_MIN     = 16'd1000;
  localparam logic [15:0] LOW_MAX     = 16'd1200;

  typedef struct packed {
    phase_t      phase;
    logic [15:0] phase_elapsed;
    logic [15:0] link_elapsed;
    logic        message_seen;
    logic        connected;
    logic [10:0] throttle;
  } eng_state_t;

  typedef struct packed {
    logic [10:0] throttle;
    logic        link_up;
    logic        link_changed;
    logic [2:0]  engine_state;
    logic        override_allowed;
    logic        message_ack;
  } eng_result_t;

endpackage

// File: rtl/ets_step.sv
module ets_step import ets_pkg::*; #(
  parameter int STAGE_MS        = 1000,
  parameter int BRAKE_HOLD_MS   = 5000,
  parameter int LINK_TIMEOUT_MS = 5000
) (
  input  eng_state_t  cur,
  input  logic [1:0]  opcode,
  input  logic [9:0]  elapsed_ms,
  input  logic        message_arrived,
  input  logic [15:0] low_throttle,
  input  logic        link_attached,
  output eng_state_t  nxt,
  output logic [15:0] low_nxt,
  output eng_result_t res
);

  localparam logic [15:0] StageLim = 16'(STAGE_MS);
  localparam logic [15:0] HoldLim  = 16'(BRAKE_HOLD_MS);
  localparam logic [15:0] LinkLim  = 16'(LINK_TIMEOUT_MS);

  logic [16:0] ph_sum, lk_sum;
  logic [15:0] ph_el, lk_el;
  logic [15:0] low_c;
  logic        conn, ack, changed;

  // saturating time advance
  assign ph_sum = {1'b0, cur.phase_elapsed} + {7'd0, elapsed_ms};
  assign lk_sum = {1'b0, cur.link_elapsed} + {7'd0, elapsed_ms};
  assign ph_el  = ph_sum[16] ? 16'hFFFF : ph_sum[15:0];
  assign lk_el  = lk_sum[16] ? 16'hFFFF : lk_sum[15:0];

  assign low_c = (low_throttle < LOW_MIN) ? LOW_MIN :
                 (low_throttle > LOW_MAX) ? LOW_MAX : low_throttle;

  always_comb begin
    nxt = cur;
    nxt.phase_elapsed = ph_el;
    nxt.link_elapsed  = lk_el;
    low_nxt = low_throttle;
    conn    = 1'b0;
    ack     = 1'b0;
    changed = 1'b0;
    case (opcode)
      OP_UPDATE: begin
        low_nxt = low_c;
        if (link_attached) begin
          if (message_arrived) begin
            nxt.link_elapsed = '0;
            nxt.message_seen = 1'b1;
            ack = 1'b1;
          end
          conn = nxt.message_seen && (nxt.link_elapsed <= LinkLim);
        end
        changed = conn != cur.connected;
        nxt.connected = conn;
        case (cur.phase)
          PH_BOOST1: begin
            nxt.throttle = THR_LOWEST;
            if (ph_el > StageLim) begin
              nxt.phase = PH_BOOST2;
              nxt.phase_elapsed = '0;
            end
          end
          PH_BOOST2: begin
            nxt.throttle = low_c[10:0];
            if (ph_el > StageLim) begin
              nxt.phase = PH_BOOST3;
              nxt.phase_elapsed = '0;
            end
          end
          PH_BOOST3: begin
            nxt.throttle = THR_HIGHEST;
            if (ph_el > StageLim) begin
              nxt.phase = PH_BOOST4;
              nxt.phase_elapsed = '0;
            end
          end
          PH_BOOST4: begin
            nxt.throttle = low_c[10:0];
            if (ph_el > StageLim) begin
              nxt.phase = PH_RUNNING;
              nxt.phase_elapsed = '0;
            end
          end
          PH_BRAKE_HOLD: begin
            nxt.throttle = low_c[10:0];
            if (ph_el > HoldLim) begin
              nxt.phase = PH_BRAKE_LOW;
              nxt.phase_elapsed = '0;
            end
          end
          PH_BRAKE_LOW: nxt.throttle = THR_LOWEST;
          default:      nxt.throttle = low_c[10:0];
        endcase
      end
      OP_BOOST: begin
        if (!(cur.connected && cur.phase == PH_RUNNING)) begin
          nxt.phase = PH_BOOST1;
          nxt.phase_elapsed = '0;
        end
      end
      OP_BRAKE: begin
        if (!(cur.connected &&
              (cur.phase == PH_BRAKE_HOLD || cur.phase == PH_BRAKE_LOW))) begin
          nxt.phase = PH_BRAKE_HOLD;
          nxt.phase_elapsed = '0;
        end
      end
      default: ; // time advance only
    endcase
  end

  assign res.throttle         = nxt.throttle;
  assign res.link_up          = nxt.connected;
  assign res.link_changed     = changed;
  assign res.engine_state     = nxt.phase;
  assign res.override_allowed = nxt.phase == PH_RUNNING;
  assign res.message_ack      = ack;

endmodule

// File: rtl/engine_throttle_sequencer.sv
// Channel | Direction | Handshake              | Word
// in      | input     | in_valid / in_ready    | opcode, elapsed_ms, message_arrived
// out     | output    | out_valid / out_ready  | throttle, link status, state, ack
// cfg     | APB slave | psel/penable, pready=1 | low_throttle @0, link_attached @4
//
// One word per cycle while out is not stalled; a word passes the input register,
// then the phase/watchdog update lands in the result register and the engine state.
// The state update for a word is one pass of ets_step, applied when the word
// moves from the input register into the result register.
// rst_n is synchronous active low; it restores the brake-lowest phase, clears
// the timers and link flags and sets both registers to their reset values.
// A stall on out holds the result; in keeps accepting until the input
// register is also occupied.
module engine_throttle_sequencer import ets_pkg::*; #(
  parameter int STAGE_MS        = 1000,
  parameter int BRAKE_HOLD_MS   = 5000,
  parameter int LINK_TIMEOUT_MS = 5000
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [9:0]  in_elapsed_ms,
  input  logic        in_message_arrived,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [10:0] out_throttle,
  output logic        out_link_up,
  output logic        out_link_changed,
  output logic [2:0]  out_engine_state,
  output logic        out_override_allowed,
  output logic        out_message_ack,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // input register
  logic        s1_valid_r;
  logic [1:0]  s1_opcode_r;
  logic [9:0]  s1_elapsed_r;
  logic        s1_msg_r;

  // result register
  logic        out_valid_r;
  eng_result_t out_res_r;

  // engine state and registers
  eng_state_t  st_r, st_nxt;
  logic [15:0] low_throttle_r, low_nxt;
  logic        link_attached_r;
  eng_result_t res_nxt;

  logic s1_adv, cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  // result register free or draining this cycle
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  ets_step #(
    .STAGE_MS        (STAGE_MS),
    .BRAKE_HOLD_MS   (BRAKE_HOLD_MS),
    .LINK_TIMEOUT_MS (LINK_TIMEOUT_MS)
  ) u_step (
    .cur             (st_r),
    .opcode          (s1_opcode_r),
    .elapsed_ms      (s1_elapsed_r),
    .message_arrived (s1_msg_r),
    .low_throttle    (low_throttle_r),
    .link_attached   (link_attached_r),
    .nxt             (st_nxt),
    .low_nxt         (low_nxt),
    .res             (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      s1_opcode_r  <= in_opcode;
      s1_elapsed_r <= in_elapsed_ms;
      s1_msg_r     <= in_message_arrived;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (s1_adv) begin
      out_res_r <= res_nxt;
    end
  end

  // engine state; an update also stores the clamped low setting back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase         <= PH_BRAKE_LOW;
      st_r.phase_elapsed <= '0;
      st_r.link_elapsed  <= '0;
      st_r.message_seen  <= 1'b0;
      st_r.connected     <= 1'b0;
      st_r.throttle      <= THR_RESET;
      low_throttle_r     <= LOW_RESET;
      link_attached_r    <= 1'b0;
    end else begin
      if (s1_adv) begin
        st_r           <= st_nxt;
        low_throttle_r <= low_nxt;
      end
      if (cfg_wr) begin
        unique case (paddr[2])
          ADDR_LOW_THROTTLE[2]:  low_throttle_r  <= pwdata[15:0];
          ADDR_LINK_ATTACHED[2]: link_attached_r <= pwdata[0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    unique case (paddr[2])
      ADDR_LINK_ATTACHED[2]: prdata = {31'd0, link_attached_r};
      default:               prdata = {16'd0, low_throttle_r};
    endcase
  end

  assign out_valid            = out_valid_r;
  assign out_throttle         = out_res_r.throttle;
  assign out_link_up          = out_res_r.link_up;
  assign out_link_changed     = out_res_r.link_changed;
  assign out_engine_state     = out_res_r.engine_state;
  assign out_override_allowed = out_res_r.override_allowed;
  assign out_message_ack      = out_res_r.message_ack;

`ifndef SYNTHESIS
  // a consumed message always leaves the link connected
  a_ack_conn: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.message_ack |-> out_res_r.link_up)
    else $error("message ack without link up");

  // throttle stays inside its pulse range
  a_thr_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_res_r.throttle >= THR_LOWEST &&
                     out_res_r.throttle <= THR_HIGHEST))
    else $error("throttle out of range");

  // phase only moves when a word passes into the result register
  a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_adv |=> $stable(st_r.phase))
    else $error("phase changed without a word");

  // reported link status tracks the stored connected flag
  a_link_track: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_res_r.link_up == st_r.connected)
    else $error("link status mismatch");
`endif

endmodule
